[hw/rtl/truss_element_response_unit_defines.svh]
// Assertion macros for the truss element response unit.
`ifndef TRUSS_ELEMENT_RESPONSE_UNIT_DEFINES_SVH
`define TRUSS_ELEMENT_RESPONSE_UNIT_DEFINES_SVH

// Same-cycle implication, reset masked.
`define TRE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define TRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tre_pkg.sv]
// Shared types, constants and functions of the truss element response unit.
package tre_pkg;

    localparam int TRE_FRAC_BITS   = 16;
    localparam int TRE_QUEUE_DEPTH = 4;
    localparam int TRE_IN_W        = 32;
    localparam int TRE_CFG_W       = 32;
    localparam int TRE_OUT_W       = 64;
    localparam int TRE_EMAG_W      = TRE_IN_W + 1;   // |node delta|
    localparam int TRE_CMAG_W      = TRE_IN_W + 2;   // |displaced delta|
    localparam int TRE_DMAG_W      = TRE_IN_W + 1;   // |displacement delta|
    localparam int TRE_LEN_SH      = 16;             // extra length scale bits
    localparam int TRE_OUT_FRAC    = 32;             // Q32.32 outputs
    localparam int TRE_ROOT_W      = 51;             // length width
    localparam int TRE_QUO_W       = 80;             // quotient cap is 2^80
    localparam int TRE_SAT_W       = TRE_QUO_W + 1 + TRE_CFG_W;
    localparam int TRE_CFG_IDX_W   = 2;

    localparam logic [TRE_CFG_W-1:0] TRE_CFG_RESET = TRE_CFG_W'(65536);

    typedef enum logic [TRE_CFG_IDX_W-1:0] {
        CFG_ELASTIC = 2'd0,
        CFG_SHEAR   = 2'd1,
        CFG_AREA    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [TRE_EMAG_W-1:0] ex_mag;
        logic [TRE_EMAG_W-1:0] ey_mag;
        logic [TRE_EMAG_W-1:0] ez_mag;
        logic [TRE_CMAG_W-1:0] cx_mag;
        logic [TRE_CMAG_W-1:0] cy_mag;
        logic [TRE_CMAG_W-1:0] cz_mag;
        logic [TRE_DMAG_W-1:0] ddy_mag;
        logic                  ddy_neg;
        logic [TRE_DMAG_W-1:0] ddz_mag;
        logic                  ddz_neg;
    } tre_item_t;

    typedef struct packed {
        logic [TRE_OUT_W-1:0] strain;
        logic [TRE_OUT_W-1:0] stress;
        logic [TRE_OUT_W-1:0] moment;
        logic [TRE_OUT_W-1:0] shear;
        logic                 zero;
    } tre_result_t;

    // Signed Q32.32 saturation of a magnitude with a sign.
    function automatic logic [TRE_OUT_W-1:0] sat64(input logic [TRE_SAT_W-1:0] m,
                                                   input logic neg);
        logic big;
        logic [TRE_OUT_W-1:0] lo;
        logic [TRE_OUT_W-1:0] res;
        big = |m[TRE_SAT_W-1:TRE_OUT_W];
        lo  = m[TRE_OUT_W-1:0];
        if (neg)
        begin
            if (big || (lo > {1'b1, {(TRE_OUT_W-1){1'b0}}}))
                res = {1'b1, {(TRE_OUT_W-1){1'b0}}};
            else
                res = -lo;
        end
        else
        begin
            if (big || lo[TRE_OUT_W-1])
                res = {1'b0, {(TRE_OUT_W-1){1'b1}}};
            else
                res = lo;
        end
        return res;
    endfunction

endpackage

[hw/rtl/tre_front.sv]
// Front end: accepts elements and reduces them to delta magnitudes and signs.
module tre_front
    import tre_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [TRE_IN_W-1:0] first_x,
    input  logic signed [TRE_IN_W-1:0] first_y,
    input  logic signed [TRE_IN_W-1:0] first_z,
    input  logic signed [TRE_IN_W-1:0] second_x,
    input  logic signed [TRE_IN_W-1:0] second_y,
    input  logic signed [TRE_IN_W-1:0] second_z,
    input  logic signed [TRE_IN_W-1:0] first_dx,
    input  logic signed [TRE_IN_W-1:0] first_dy,
    input  logic signed [TRE_IN_W-1:0] first_dz,
    input  logic signed [TRE_IN_W-1:0] second_dx,
    input  logic signed [TRE_IN_W-1:0] second_dy,
    input  logic signed [TRE_IN_W-1:0] second_dz,
    input  logic                       full,
    output logic                       push,
    output tre_item_t                  item
);

    logic      front_valid_reg;
    tre_item_t item_reg;
    tre_item_t item_next;

    logic signed [TRE_IN_W:0]   ex, ey, ez, ddy, ddz;
    logic signed [TRE_IN_W:0]   p2x, p2y, p2z, p1x, p1y, p1z;
    logic signed [TRE_IN_W+1:0] cx, cy, cz;

    always_comb
    begin
        ex  = {second_x[TRE_IN_W-1], second_x} - {first_x[TRE_IN_W-1], first_x};
        ey  = {second_y[TRE_IN_W-1], second_y} - {first_y[TRE_IN_W-1], first_y};
        ez  = {second_z[TRE_IN_W-1], second_z} - {first_z[TRE_IN_W-1], first_z};
        p2x = {second_x[TRE_IN_W-1], second_x} + {second_dx[TRE_IN_W-1], second_dx};
        p2y = {second_y[TRE_IN_W-1], second_y} + {second_dy[TRE_IN_W-1], second_dy};
        p2z = {second_z[TRE_IN_W-1], second_z} + {second_dz[TRE_IN_W-1], second_dz};
        p1x = {first_x[TRE_IN_W-1], first_x} + {first_dx[TRE_IN_W-1], first_dx};
        p1y = {first_y[TRE_IN_W-1], first_y} + {first_dy[TRE_IN_W-1], first_dy};
        p1z = {first_z[TRE_IN_W-1], first_z} + {first_dz[TRE_IN_W-1], first_dz};
        cx  = {p2x[TRE_IN_W], p2x} - {p1x[TRE_IN_W], p1x};
        cy  = {p2y[TRE_IN_W], p2y} - {p1y[TRE_IN_W], p1y};
        cz  = {p2z[TRE_IN_W], p2z} - {p1z[TRE_IN_W], p1z};
        ddy = {second_dy[TRE_IN_W-1], second_dy} - {first_dy[TRE_IN_W-1], first_dy};
        ddz = {second_dz[TRE_IN_W-1], second_dz} - {first_dz[TRE_IN_W-1], first_dz};

        item_next.ex_mag  = ex[TRE_IN_W] ? TRE_EMAG_W'(-ex) : TRE_EMAG_W'(ex);
        item_next.ey_mag  = ey[TRE_IN_W] ? TRE_EMAG_W'(-ey) : TRE_EMAG_W'(ey);
        item_next.ez_mag  = ez[TRE_IN_W] ? TRE_EMAG_W'(-ez) : TRE_EMAG_W'(ez);
        item_next.cx_mag  = cx[TRE_IN_W+1] ? TRE_CMAG_W'(-cx) : TRE_CMAG_W'(cx);
        item_next.cy_mag  = cy[TRE_IN_W+1] ? TRE_CMAG_W'(-cy) : TRE_CMAG_W'(cy);
        item_next.cz_mag  = cz[TRE_IN_W+1] ? TRE_CMAG_W'(-cz) : TRE_CMAG_W'(cz);
        item_next.ddy_mag = ddy[TRE_IN_W] ? TRE_DMAG_W'(-ddy) : TRE_DMAG_W'(ddy);
        item_next.ddy_neg = ddy[TRE_IN_W];
        item_next.ddz_mag = ddz[TRE_IN_W] ? TRE_DMAG_W'(-ddz) : TRE_DMAG_W'(ddz);
        item_next.ddz_neg = ddz[TRE_IN_W];
    end

    assign in_ready = !front_valid_reg || !full;
    assign push     = front_valid_reg && !full;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (in_ready)
            front_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

[hw/rtl/tre_queue.sv]
// Short FIFO between front and back end (depth must be a power of two).
module tre_queue
    import tre_pkg::*;
#(
    parameter int DEPTH = TRE_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tre_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      valid,
    output tre_item_t head
);

    localparam int PTR_W = $clog2(DEPTH);

    tre_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

[hw/rtl/tre_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
module tre_isqrt
    import tre_pkg::*;
#(
    parameter int ROOT_W = TRE_ROOT_W
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   x,
    output logic [ROOT_W-1:0]     root
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = ROOT_W + 4;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [X_W-1:0]    xs_reg   [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [X_W-1:0]    xs_in;
            logic [TRY_W-1:0]  cur;
            logic [TRY_W-1:0]  trial;
            logic              fit;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign xs_in   = x;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign xs_in   = xs_reg[k-1];
            end

            assign cur   = {rem_in, xs_in[X_W-1 -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign fit   = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= fit ? REM_W'(cur - trial) : REM_W'(cur);
                    root_reg[k] <= {root_in[ROOT_W-2:0], fit};
                    xs_reg[k]   <= {xs_in[X_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

[hw/rtl/tre_div.sv]
// Pipelined restoring divider, quotient capped at 2^QW, one bit per stage.
module tre_div
    import tre_pkg::*;
#(
    parameter int NUM_W = 83,
    parameter int DEN_W = TRE_ROOT_W,
    parameter int QW    = TRE_QUO_W
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW:0]      quo
);

    localparam int HI_W  = NUM_W - QW;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg [QW+1];
    logic [QW-1:0]    bits_reg [QW+1];   // dividend bits out, quotient bits in
    logic [DEN_W-1:0] den_reg [QW+1];
    logic             cap_reg [QW+1];

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;
    logic             cap0;

    assign hi_ext  = CMP_W'(num[NUM_W-1:QW]);
    assign den_ext = CMP_W'(den);
    assign cap0    = (hi_ext >= den_ext);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= cap0 ? '0 : hi_ext[DEN_W-1:0];
            bits_reg[0] <= num[QW-1:0];
            den_reg[0]  <= den;
            cap_reg[0]  <= cap0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_stage
            logic [DEN_W:0] cur;
            logic           fit;

            assign cur = {rem_reg[k-1], bits_reg[k-1][QW-1]};
            assign fit = (cur >= {1'b0, den_reg[k-1]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= fit ? DEN_W'(cur - {1'b0, den_reg[k-1]}) : DEN_W'(cur);
                    bits_reg[k] <= {bits_reg[k-1][QW-2:0], fit};
                    den_reg[k]  <= den_reg[k-1];
                    cap_reg[k]  <= cap_reg[k-1];
                end
            end
        end
    endgenerate

    assign quo = cap_reg[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, bits_reg[QW]};

endmodule

[hw/rtl/tre_back.sv]
// Back end: lengths, quotients, stress product, saturation and output register.
module tre_back
    import tre_pkg::*;
#(
    parameter int FRAC_BITS = TRE_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  tre_item_t            q_item,
    output logic                 pop,
    input  logic [TRE_CFG_W-1:0] elastic_modulus,
    input  logic [TRE_CFG_W-1:0] shear_modulus,
    input  logic [TRE_CFG_W-1:0] section_area,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tre_result_t          result
);

    localparam int X_W      = 2 * TRE_ROOT_W;
    localparam int SQE_W    = 2 * TRE_EMAG_W;
    localparam int SQC_W    = 2 * TRE_CMAG_W;
    localparam int EY_W     = TRE_CFG_W + TRE_DMAG_W;
    localparam int GA_W     = 2 * TRE_CFG_W;
    localparam int SH_W     = GA_W + TRE_DMAG_W;
    localparam int MOM_SH   = TRE_OUT_FRAC + TRE_LEN_SH - FRAC_BITS;
    localparam int SHR_SH   = TRE_OUT_FRAC + TRE_LEN_SH - 2 * FRAC_BITS;
    localparam int STR_W    = TRE_ROOT_W + TRE_OUT_FRAC;
    localparam int MOM_W    = EY_W + MOM_SH;
    localparam int SHR_W    = SH_W + SHR_SH;
    localparam int SIDE_LAT = 2 + TRE_ROOT_W;
    localparam int DIV_LAT  = TRE_QUO_W + 1;
    localparam int Q_W      = TRE_QUO_W + 1;
    localparam int HALF_W   = TRE_CFG_W;

    typedef struct packed {
        logic [TRE_DMAG_W-1:0] ddy_mag;
        logic                  ddy_neg;
        logic [TRE_DMAG_W-1:0] ddz_mag;
        logic                  ddz_neg;
    } side_t;

    typedef struct packed {
        logic neg;
        logic zero;
        logic ddy_neg;
        logic ddz_neg;
    } tail_t;

    logic adv;

    // valid line
    logic [SIDE_LAT-1:0] side_vld_reg;
    logic [2:0]          c_vld_reg;
    logic [DIV_LAT-1:0]  tail_vld_reg;
    logic                d1_vld_reg;
    logic                out_valid_reg;

    // squares and sums
    logic [SQE_W-1:0]   sqe_reg [3];
    logic [SQC_W-1:0]   sqc_reg [3];
    logic [SQE_W-1:0]   l0_sq_reg;
    logic [SQC_W-1:0]   lc_sq_reg;
    side_t              side_reg [SIDE_LAT];

    logic [TRE_ROOT_W-1:0] l0_root;
    logic [TRE_ROOT_W-1:0] lc_root;

    // numerator stages
    logic [TRE_ROOT_W-1:0] diff_reg [3];
    logic [TRE_ROOT_W-1:0] l0_reg   [3];
    logic [EY_W-1:0]       ey_reg   [3];
    tail_t                 ctail_reg [3];
    logic [GA_W-1:0]       ga_reg;
    logic [TRE_DMAG_W-1:0] ddz_mag_reg;
    logic [SH_W-1:0]       sh_lo_reg;
    logic [SH_W-1:0]       sh_hi_reg;
    logic [SH_W-1:0]       sh_num_reg;

    tail_t                 tail_reg [DIV_LAT];

    logic [Q_W-1:0] q_str;
    logic [Q_W-1:0] q_mom;
    logic [Q_W-1:0] q_shr;

    // final stages
    logic [TRE_OUT_W-1:0]      strain_d1_reg;
    logic [TRE_OUT_W-1:0]      moment_d1_reg;
    logic [TRE_OUT_W-1:0]      shear_d1_reg;
    logic [2*HALF_W-1:0]       p0_reg;
    logic [2*HALF_W-1:0]       p1_reg;
    logic [Q_W-2*HALF_W+TRE_CFG_W-1:0] p2_reg;
    tail_t                     d1_tail_reg;

    logic [TRE_SAT_W-1:0] st_full;
    logic [TRE_SAT_W-1:0] st_shift;
    tre_result_t          out_reg;
    tre_result_t          out_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && q_valid;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_vld_reg  <= '0;
            c_vld_reg     <= '0;
            tail_vld_reg  <= '0;
            d1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            side_vld_reg  <= {side_vld_reg[SIDE_LAT-2:0], q_valid};
            c_vld_reg     <= {c_vld_reg[1:0], side_vld_reg[SIDE_LAT-1]};
            tail_vld_reg  <= {tail_vld_reg[DIV_LAT-2:0], c_vld_reg[2]};
            d1_vld_reg    <= tail_vld_reg[DIV_LAT-1];
            out_valid_reg <= d1_vld_reg;
        end
    end

    // squares, then sums that feed both root units
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqe_reg[0] <= SQE_W'(q_item.ex_mag) * SQE_W'(q_item.ex_mag);
            sqe_reg[1] <= SQE_W'(q_item.ey_mag) * SQE_W'(q_item.ey_mag);
            sqe_reg[2] <= SQE_W'(q_item.ez_mag) * SQE_W'(q_item.ez_mag);
            sqc_reg[0] <= SQC_W'(q_item.cx_mag) * SQC_W'(q_item.cx_mag);
            sqc_reg[1] <= SQC_W'(q_item.cy_mag) * SQC_W'(q_item.cy_mag);
            sqc_reg[2] <= SQC_W'(q_item.cz_mag) * SQC_W'(q_item.cz_mag);
            l0_sq_reg  <= sqe_reg[0] + sqe_reg[1] + sqe_reg[2];
            lc_sq_reg  <= sqc_reg[0] + sqc_reg[1] + sqc_reg[2];

            side_reg[0].ddy_mag <= q_item.ddy_mag;
            side_reg[0].ddy_neg <= q_item.ddy_neg;
            side_reg[0].ddz_mag <= q_item.ddz_mag;
            side_reg[0].ddz_neg <= q_item.ddz_neg;
            for (int i = 1; i < SIDE_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    tre_isqrt #(.ROOT_W(TRE_ROOT_W)) u_sqrt_l0 (
        .clk  (clk),
        .en   (adv),
        .x    (X_W'({l0_sq_reg, {(2*TRE_LEN_SH){1'b0}}})),
        .root (l0_root)
    );

    tre_isqrt #(.ROOT_W(TRE_ROOT_W)) u_sqrt_lc (
        .clk  (clk),
        .en   (adv),
        .x    (X_W'({lc_sq_reg, {(2*TRE_LEN_SH){1'b0}}})),
        .root (lc_root)
    );

    // numerators: length difference, E*|ddy|, G*A*|ddz| in two halves
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg[0] <= (lc_root < l0_root) ? (l0_root - lc_root) : (lc_root - l0_root);
            l0_reg[0]   <= l0_root;
            ey_reg[0]   <= EY_W'(elastic_modulus) * EY_W'(side_reg[SIDE_LAT-1].ddy_mag);
            ga_reg      <= GA_W'(shear_modulus) * GA_W'(section_area);
            ddz_mag_reg <= side_reg[SIDE_LAT-1].ddz_mag;
            ctail_reg[0].neg     <= (lc_root < l0_root);
            ctail_reg[0].zero    <= (l0_root == '0);
            ctail_reg[0].ddy_neg <= side_reg[SIDE_LAT-1].ddy_neg;
            ctail_reg[0].ddz_neg <= side_reg[SIDE_LAT-1].ddz_neg;

            sh_lo_reg <= SH_W'(ga_reg[HALF_W-1:0]) * SH_W'(ddz_mag_reg);
            sh_hi_reg <= SH_W'(ga_reg[GA_W-1:HALF_W]) * SH_W'(ddz_mag_reg);
            sh_num_reg <= sh_lo_reg + (sh_hi_reg << HALF_W);

            for (int i = 1; i < 3; i++)
            begin
                diff_reg[i]  <= diff_reg[i-1];
                l0_reg[i]    <= l0_reg[i-1];
                ey_reg[i]    <= ey_reg[i-1];
                ctail_reg[i] <= ctail_reg[i-1];
            end

            tail_reg[0] <= ctail_reg[2];
            for (int i = 1; i < DIV_LAT; i++)
                tail_reg[i] <= tail_reg[i-1];
        end
    end

    tre_div #(.NUM_W(STR_W), .DEN_W(TRE_ROOT_W), .QW(TRE_QUO_W)) u_div_strain (
        .clk (clk),
        .en  (adv),
        .num (STR_W'(diff_reg[2]) << TRE_OUT_FRAC),
        .den (l0_reg[2]),
        .quo (q_str)
    );

    tre_div #(.NUM_W(MOM_W), .DEN_W(TRE_ROOT_W), .QW(TRE_QUO_W)) u_div_moment (
        .clk (clk),
        .en  (adv),
        .num (MOM_W'(ey_reg[2]) << MOM_SH),
        .den (l0_reg[2]),
        .quo (q_mom)
    );

    tre_div #(.NUM_W(SHR_W), .DEN_W(TRE_ROOT_W), .QW(TRE_QUO_W)) u_div_shear (
        .clk (clk),
        .en  (adv),
        .num (SHR_W'(sh_num_reg) << SHR_SH),
        .den (l0_reg[2]),
        .quo (q_shr)
    );

    // saturate quotients, split strain times E into partial products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            strain_d1_reg <= sat64(TRE_SAT_W'(q_str), tail_reg[DIV_LAT-1].neg);
            moment_d1_reg <= sat64(TRE_SAT_W'(q_mom), tail_reg[DIV_LAT-1].ddy_neg);
            shear_d1_reg  <= sat64(TRE_SAT_W'(q_shr), tail_reg[DIV_LAT-1].ddz_neg);
            p0_reg <= (2*HALF_W)'(q_str[HALF_W-1:0]) * (2*HALF_W)'(elastic_modulus);
            p1_reg <= (2*HALF_W)'(q_str[2*HALF_W-1:HALF_W]) * (2*HALF_W)'(elastic_modulus);
            p2_reg <= $bits(p2_reg)'(q_str[Q_W-1:2*HALF_W]) * $bits(p2_reg)'(elastic_modulus);
            d1_tail_reg <= tail_reg[DIV_LAT-1];
        end
    end

    always_comb
    begin
        st_full  = TRE_SAT_W'(p0_reg) + (TRE_SAT_W'(p1_reg) << HALF_W)
                 + (TRE_SAT_W'(p2_reg) << (2*HALF_W));
        st_shift = st_full >> FRAC_BITS;
        if (d1_tail_reg.zero)
        begin
            out_next.strain = '0;
            out_next.stress = '0;
            out_next.moment = '0;
            out_next.shear  = '0;
            out_next.zero   = 1'b1;
        end
        else
        begin
            out_next.strain = strain_d1_reg;
            out_next.stress = sat64(st_shift, d1_tail_reg.neg);
            out_next.moment = moment_d1_reg;
            out_next.shear  = shear_d1_reg;
            out_next.zero   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

endmodule

[hw/rtl/truss_element_response_unit.sv]
// Throughput: one element per cycle unless the output stalls; set by the bit-per-stage root and divider pipelines.
// Front register and 4-entry queue let the input side keep accepting while the back stalls.
// Reset (rst_n low, async): pipeline, queue and output valids clear; E, G and A return to 1.0.
// Payload registers are not reset; no clearing pass is needed.
// Top level: config registers, front end, queue, back end.
`include "truss_element_response_unit_defines.svh"

module truss_element_response_unit
    import tre_pkg::*;
#(
    parameter int FRAC_BITS   = TRE_FRAC_BITS,
    parameter int QUEUE_DEPTH = TRE_QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration write port
    input  logic                        cfg_we,
    input  logic [TRE_CFG_IDX_W-1:0]    cfg_index,
    input  logic [TRE_CFG_W-1:0]        cfg_data,

    // element input transaction
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [TRE_IN_W-1:0]  first_x,
    input  logic signed [TRE_IN_W-1:0]  first_y,
    input  logic signed [TRE_IN_W-1:0]  first_z,
    input  logic signed [TRE_IN_W-1:0]  second_x,
    input  logic signed [TRE_IN_W-1:0]  second_y,
    input  logic signed [TRE_IN_W-1:0]  second_z,
    input  logic signed [TRE_IN_W-1:0]  first_dx,
    input  logic signed [TRE_IN_W-1:0]  first_dy,
    input  logic signed [TRE_IN_W-1:0]  first_dz,
    input  logic signed [TRE_IN_W-1:0]  second_dx,
    input  logic signed [TRE_IN_W-1:0]  second_dy,
    input  logic signed [TRE_IN_W-1:0]  second_dz,

    // result transaction
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [TRE_OUT_W-1:0] strain_out,
    output logic signed [TRE_OUT_W-1:0] stress_out,
    output logic signed [TRE_OUT_W-1:0] moment_out,
    output logic signed [TRE_OUT_W-1:0] shear_out,
    output logic                        zero_length
);

    // Material and section registers, unsigned Q format; the user must write them only while idle (unchecked).
    logic [TRE_CFG_W-1:0] elastic_modulus_reg;
    logic [TRE_CFG_W-1:0] shear_modulus_reg;
    logic [TRE_CFG_W-1:0] section_area_reg;

    // front -> queue
    logic      push;
    logic      full;
    tre_item_t front_item;

    // queue -> back
    logic      q_valid;
    logic      pop;
    tre_item_t q_item;

    tre_result_t result;

    // Register writes; an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elastic_modulus_reg <= TRE_CFG_RESET;
            shear_modulus_reg   <= TRE_CFG_RESET;
            section_area_reg    <= TRE_CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ELASTIC: elastic_modulus_reg <= cfg_data;
                CFG_SHEAR:   shear_modulus_reg   <= cfg_data;
                CFG_AREA:    section_area_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Front end: one register stage forms coordinate deltas as magnitudes and the y and z
    // displacement deltas as magnitude/sign pairs, then hands the element to the queue.
    tre_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .first_x   (first_x),
        .first_y   (first_y),
        .first_z   (first_z),
        .second_x  (second_x),
        .second_y  (second_y),
        .second_z  (second_z),
        .first_dx  (first_dx),
        .first_dy  (first_dy),
        .first_dz  (first_dz),
        .second_dx (second_dx),
        .second_dy (second_dy),
        .second_dz (second_dz),
        .full      (full),
        .push      (push),
        .item      (front_item)
    );

    // Decoupling queue: absorbs back-end stalls so the front keeps streaming until it fills.
    tre_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (full),
        .valid     (q_valid),
        .head      (q_item)
    );

    // Back end: squares and sums (2 stages), two 51-stage square roots,
    // numerator build (3 stages), three 81-stage capped dividers, stress
    // partial products and saturation (1 stage), output register.
    // The whole back end advances together whenever the output can move.
    tre_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .pop             (pop),
        .elastic_modulus (elastic_modulus_reg),
        .shear_modulus   (shear_modulus_reg),
        .section_area    (section_area_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result          (result)
    );

    assign strain_out  = result.strain;
    assign stress_out  = result.stress;
    assign moment_out  = result.moment;
    assign shear_out   = result.shear;
    assign zero_length = result.zero;

    // Queue is never written when full.
    `TRE_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into full queue")

    // An accepted element sits in the front register next cycle: it either
    // moves into the queue or waits on a full queue.
    `TRE_ASSERT_NEXT(a_front_holds, clk, rst_n, in_valid && in_ready, push || full,
        "accepted element lost in front end")

    // A degenerate element reports all-zero results.
    `TRE_ASSERT_IMPL(a_zero_len, clk, rst_n, out_valid && zero_length,
        (strain_out == '0) && (stress_out == '0) && (moment_out == '0) && (shear_out == '0),
        "nonzero result with zero initial length")

endmodule
